[sv/xsdd_pkg.sv]
package xsdd_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [63:0] ticks;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_SIGNED = 4'd1,
      PH_P0     = 4'd2,
      PH_P1     = 4'd3,
      PH_P2     = 4'd4,
      PH_P3     = 4'd5,
      PH_T0     = 4'd6,
      PH_T1     = 4'd7,
      PH_T2     = 4'd8,
      PH_FRAC   = 4'd9,
      PH_DONE   = 4'd10
   } phase_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } bk_state_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_FMT = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;

   localparam int unsigned NUM_COMPS = 6;
   localparam int unsigned COMP_W    = 31;
   localparam int unsigned FRAC_W    = 30;

   localparam logic [30:0] COMP_MAX = 31'h7FFF_FFFF;

   localparam logic [2:0] CI_YEAR  = 3'd0;
   localparam logic [2:0] CI_MONTH = 3'd1;
   localparam logic [2:0] CI_DAY   = 3'd2;
   localparam logic [2:0] CI_HOUR  = 3'd3;
   localparam logic [2:0] CI_MIN   = 3'd4;
   localparam logic [2:0] CI_SEC   = 3'd5;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Y     = 8'h59;

   // x / 12 == (x * MUL12) >> 35 for any 32-bit x
   localparam logic [31:0] MUL12   = 32'hAAAA_AAAB;
   // (x >> 2) / 25 == ((x >> 2) * MUL25) >> 38 for x below 2^30
   localparam logic [33:0] MUL25   = 34'd10995116278;
   localparam logic [63:0] SEC_MAX = 64'd922337203685;
   localparam logic [23:0] TICKS_PER_SEC = 24'd10000000;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]                         status;
      logic                               neg;
      logic [NUM_COMPS-1:0][COMP_W-1:0]   comps;
      logic [FRAC_W-1:0]                  frac;
   } job_type;

   // pads a short fraction out to nine digits
   function automatic logic [29:0] frac_scale(input logic [3:0] n);
      logic [29:0] s;
      case (n)
         4'd0:    s = 30'd1000000000;
         4'd1:    s = 30'd100000000;
         4'd2:    s = 30'd10000000;
         4'd3:    s = 30'd1000000;
         4'd4:    s = 30'd100000;
         4'd5:    s = 30'd10000;
         4'd6:    s = 30'd1000;
         4'd7:    s = 30'd100;
         4'd8:    s = 30'd10;
         default: s = 30'd1;
      endcase
      return s;
   endfunction

endpackage

[sv/xsdd_front.sv]
module xsdd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  xsdd_pkg::req_type req_data,
   input  logic              req_stall,
   output logic              push,
   output xsdd_pkg::job_type job
);

   xsdd_pkg::phase_type phase_ff, phase_in, phase_pre;
   logic        neg_ff, neg_in, neg_pre;
   logic [30:0] acc_ff, acc_in, acc_pre;
   logic [3:0]  dc_ff, dc_in, dc_pre;
   logic [5:0][30:0] comps_ff, comps_in, comps_pre;
   logic [29:0] frac_ff, frac_in, frac_pre;
   logic        any_ff, any_in, any_pre;
   logic [1:0]  err_ff, err_in, err_pre;

   logic        accept, live, is_dig, in_comp, dig_ovf;
   logic [7:0]  c;
   logic [3:0]  d;
   logic [34:0] acc_next;
   logic        minus_ev, p_ev, take_ev, t_ev, dot_ev, sf_ev;
   logic [2:0]  take_idx;
   xsdd_pkg::phase_type take_nxt;
   logic        ends_ok;
   logic [59:0] frac_padded;

   assign c        = req_data.char_code;
   assign d        = c[3:0];
   assign accept   = req_valid && !req_stall;
   assign live     = accept && (err_ff == xsdd_pkg::ST_OK);
   assign is_dig   = c inside {[xsdd_pkg::CH_ZERO:xsdd_pkg::CH_NINE]};
   assign in_comp  = (phase_ff >= xsdd_pkg::PH_P0) && (phase_ff <= xsdd_pkg::PH_T2);
   assign acc_next = 35'(acc_ff) * 35'd10 + 35'(d);
   assign dig_ovf  = acc_next > 35'(xsdd_pkg::COMP_MAX);
   assign frac_padded = 60'(frac_ff) * 60'(xsdd_pkg::frac_scale(dc_ff));

   assign minus_ev = (phase_ff == xsdd_pkg::PH_START) && (c == xsdd_pkg::CH_MINUS);
   assign p_ev     = ((phase_ff == xsdd_pkg::PH_START) || (phase_ff == xsdd_pkg::PH_SIGNED))
                     && (c == xsdd_pkg::CH_P);
   assign t_ev     = (c == xsdd_pkg::CH_T) && (phase_ff >= xsdd_pkg::PH_P0)
                     && (phase_ff <= xsdd_pkg::PH_P3);
   assign dot_ev   = (c == xsdd_pkg::CH_DOT) && (phase_ff >= xsdd_pkg::PH_T0)
                     && (phase_ff <= xsdd_pkg::PH_T2);
   assign sf_ev    = (c == xsdd_pkg::CH_S) && (phase_ff == xsdd_pkg::PH_FRAC);

   // designators that close a component run
   always_comb begin
      take_ev  = 1'b1;
      take_idx = xsdd_pkg::CI_YEAR;
      take_nxt = xsdd_pkg::PH_P1;
      if (c == xsdd_pkg::CH_Y && phase_ff == xsdd_pkg::PH_P0) begin
         take_idx = xsdd_pkg::CI_YEAR;
         take_nxt = xsdd_pkg::PH_P1;
      end else if (c == xsdd_pkg::CH_M && (phase_ff == xsdd_pkg::PH_P0 ||
                                           phase_ff == xsdd_pkg::PH_P1)) begin
         take_idx = xsdd_pkg::CI_MONTH;
         take_nxt = xsdd_pkg::PH_P2;
      end else if (c == xsdd_pkg::CH_D && phase_ff >= xsdd_pkg::PH_P0
                   && phase_ff <= xsdd_pkg::PH_P2) begin
         take_idx = xsdd_pkg::CI_DAY;
         take_nxt = xsdd_pkg::PH_P3;
      end else if (c == xsdd_pkg::CH_H && phase_ff == xsdd_pkg::PH_T0) begin
         take_idx = xsdd_pkg::CI_HOUR;
         take_nxt = xsdd_pkg::PH_T1;
      end else if (c == xsdd_pkg::CH_M && (phase_ff == xsdd_pkg::PH_T0 ||
                                           phase_ff == xsdd_pkg::PH_T1)) begin
         take_idx = xsdd_pkg::CI_MIN;
         take_nxt = xsdd_pkg::PH_T2;
      end else if (c == xsdd_pkg::CH_S && phase_ff >= xsdd_pkg::PH_T0
                   && phase_ff <= xsdd_pkg::PH_T2) begin
         take_idx = xsdd_pkg::CI_SEC;
         take_nxt = xsdd_pkg::PH_DONE;
      end else begin
         take_ev = 1'b0;
      end
   end

   // next phase
   always_comb begin
      phase_pre = phase_ff;
      if (live) begin
         if (is_dig) begin
            phase_pre = phase_ff;
         end else if (minus_ev) begin
            phase_pre = xsdd_pkg::PH_SIGNED;
         end else if (p_ev) begin
            phase_pre = xsdd_pkg::PH_P0;
         end else if (take_ev) begin
            if (dc_ff != 4'd0) phase_pre = take_nxt;
         end else if (t_ev) begin
            if (dc_ff == 4'd0) phase_pre = xsdd_pkg::PH_T0;
         end else if (dot_ev) begin
            phase_pre = xsdd_pkg::PH_FRAC;
         end else if (sf_ev) begin
            phase_pre = xsdd_pkg::PH_DONE;
         end
      end
      phase_in = (accept && req_data.last_char) ? xsdd_pkg::PH_START : phase_pre;
   end

   // datapath
   always_comb begin
      neg_pre   = neg_ff;
      acc_pre   = acc_ff;
      dc_pre    = dc_ff;
      comps_pre = comps_ff;
      frac_pre  = frac_ff;
      any_pre   = any_ff;
      err_pre   = err_ff;
      if (live) begin
         if (is_dig) begin
            if (phase_ff == xsdd_pkg::PH_FRAC) begin
               if (dc_ff < 4'd9) begin
                  frac_pre = 30'(34'(frac_ff) * 34'd10 + 34'(d));
                  dc_pre   = dc_ff + 4'd1;
               end
            end else if (in_comp) begin
               if (dig_ovf) begin
                  err_pre = xsdd_pkg::ST_OVF;
               end else begin
                  acc_pre = acc_next[30:0];
                  if (dc_ff != 4'd15) dc_pre = dc_ff + 4'd1;
               end
            end else begin
               err_pre = xsdd_pkg::ST_FMT;
            end
         end else if (minus_ev) begin
            neg_pre = 1'b1;
         end else if (p_ev) begin
            neg_pre = neg_ff;
         end else if (take_ev) begin
            if (dc_ff == 4'd0) begin
               err_pre = xsdd_pkg::ST_FMT;
            end else begin
               comps_pre[take_idx] = acc_ff;
               any_pre = 1'b1;
               acc_pre = '0;
               dc_pre  = '0;
            end
         end else if (t_ev) begin
            if (dc_ff != 4'd0) err_pre = xsdd_pkg::ST_FMT;
         end else if (dot_ev) begin
            comps_pre[xsdd_pkg::CI_SEC] = acc_ff;
            any_pre  = 1'b1;
            acc_pre  = '0;
            dc_pre   = '0;
            frac_pre = '0;
         end else if (sf_ev) begin
            frac_pre = frac_padded[29:0];
            dc_pre   = '0;
         end else begin
            err_pre = xsdd_pkg::ST_FMT;
         end
      end
      if (accept && req_data.last_char) begin
         neg_in   = 1'b0;
         acc_in   = '0;
         dc_in    = '0;
         comps_in = '0;
         frac_in  = '0;
         any_in   = 1'b0;
         err_in   = xsdd_pkg::ST_OK;
      end else begin
         neg_in   = neg_pre;
         acc_in   = acc_pre;
         dc_in    = dc_pre;
         comps_in = comps_pre;
         frac_in  = frac_pre;
         any_in   = any_pre;
         err_in   = err_pre;
      end
   end

   assign ends_ok = (phase_pre == xsdd_pkg::PH_P1 || phase_pre == xsdd_pkg::PH_P2 ||
                     phase_pre == xsdd_pkg::PH_P3 || phase_pre == xsdd_pkg::PH_T1 ||
                     phase_pre == xsdd_pkg::PH_T2 || phase_pre == xsdd_pkg::PH_DONE)
                    && dc_pre == 4'd0 && any_pre;

   assign push       = accept && req_data.last_char;
   assign job.status = (err_pre != xsdd_pkg::ST_OK) ? err_pre :
                       (ends_ok ? xsdd_pkg::ST_OK : xsdd_pkg::ST_FMT);
   assign job.neg    = neg_pre;
   assign job.comps  = comps_pre;
   assign job.frac   = frac_pre;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xsdd_pkg::PH_START;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         dc_ff    <= '0;
         comps_ff <= '0;
         frac_ff  <= '0;
         any_ff   <= 1'b0;
         err_ff   <= xsdd_pkg::ST_OK;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         dc_ff    <= dc_in;
         comps_ff <= comps_in;
         frac_ff  <= frac_in;
         any_ff   <= any_in;
         err_ff   <= err_in;
      end
   end

endmodule

[sv/xsdd_fifo.sv]
module xsdd_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xsdd_pkg::job_type push_data,
   input  logic              pop,
   output xsdd_pkg::job_type pop_data,
   output logic              full,
   output logic              empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   xsdd_pkg::job_type    slots_ff [DEPTH];
   logic [PTR_W-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slots_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      if (pop)  rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[sv/xsdd_back.sv]
module xsdd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  xsdd_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   output xsdd_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);

   xsdd_pkg::bk_state_type state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   xsdd_pkg::job_type job_ff;
   logic [63:0]       t_ff, t_in;
   logic [27:0]       q_ff, q_in;
   logic [3:0]        r_ff, r_in;
   logic [23:0]       fr_ff, fr_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   xsdd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        out_free, finish, load;
   logic [62:0] q_prod;
   logic [61:0] fr_prod;
   logic [63:0] t_ticks, t_neg;
   logic        fin_ovf;
   logic [1:0]  fin_status;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == xsdd_pkg::BK_RUN) && (step_ff == 3'd7) && out_free;
   assign load     = (state_ff == xsdd_pkg::BK_IDLE) && job_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xsdd_pkg::BK_IDLE: if (job_ready) state_in = xsdd_pkg::BK_RUN;
         xsdd_pkg::BK_RUN:  if (finish) state_in = xsdd_pkg::BK_IDLE;
         default:           state_in = xsdd_pkg::BK_IDLE;
      endcase
   end

   assign q_prod  = 63'(job_ff.comps[xsdd_pkg::CI_MONTH]) * 63'(xsdd_pkg::MUL12);
   assign fr_prod = 62'(job_ff.frac[29:2]) * 62'(xsdd_pkg::MUL25);
   assign t_ticks = 64'(t_ff[39:0]) * 64'(xsdd_pkg::TICKS_PER_SEC) + 64'(fr_ff);
   assign t_neg   = 64'd0 - t_ff;
   assign fin_ovf = ovf_ff || (job_ff.neg ? (t_ff > xsdd_pkg::NEG_MAX)
                                          : (t_ff > xsdd_pkg::POS_MAX));
   assign fin_status = (job_ff.status != xsdd_pkg::ST_OK) ? job_ff.status :
                       (fin_ovf ? xsdd_pkg::ST_OVF : xsdd_pkg::ST_OK);

   // one step of the tick sum per cycle; the last step waits while rsp_stall holds the result
   always_comb begin
      step_in      = step_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      fr_in        = fr_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      job_pop      = load;
      if (load) begin
         step_in = '0;
         ovf_in  = 1'b0;
      end else if (state_ff == xsdd_pkg::BK_RUN) begin
         case (step_ff)
            3'd0: begin
               q_in = q_prod[62:35];
            end
            3'd1: begin
               r_in  = 4'(job_ff.comps[xsdd_pkg::CI_MONTH] - 31'(q_ff) * 31'd12);
               t_in  = 64'(job_ff.comps[xsdd_pkg::CI_YEAR]) + 64'(q_ff);
               fr_in = fr_prod[61:38];
            end
            3'd2: t_in = t_ff * 64'd365 + 64'(r_ff) * 64'd30
                         + 64'(job_ff.comps[xsdd_pkg::CI_DAY]);
            3'd3: t_in = t_ff * 64'd24 + 64'(job_ff.comps[xsdd_pkg::CI_HOUR]);
            3'd4: t_in = t_ff * 64'd60 + 64'(job_ff.comps[xsdd_pkg::CI_MIN]);
            3'd5: t_in = t_ff * 64'd60 + 64'(job_ff.comps[xsdd_pkg::CI_SEC]);
            3'd6: begin
               ovf_in = t_ff > xsdd_pkg::SEC_MAX;
               t_in   = t_ticks;
            end
            default: begin
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = fin_status;
                  rsp_data_in.ticks  = (fin_status != xsdd_pkg::ST_OK) ? 64'sd0 :
                                       (job_ff.neg ? $signed(t_neg) : $signed(t_ff));
               end
            end
         endcase
         if (step_ff != 3'd7) step_in = step_ff + 3'd1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (load) job_ff <= job_data;
      t_ff        <= t_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      fr_ff       <= fr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xsdd_pkg::BK_IDLE;
         step_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/xsd_duration_to_ticks_parser_core.sv]
// Duration text to 100 ns tick count.
// req_ channel: one ASCII byte per beat (char_code), last_char marks the
// final byte of a string. A byte is taken on every cycle that req_valid is
// high and req_stall is low.
// rsp_ channel: one beat per string, status (0 valid, 1 bad format,
// 2 overflow) and signed ticks, zero unless status is 0.
// The parser hands each finished string to a job queue of FIFO_DEPTH
// entries; the tick arithmetic unit then works on one string at a time
// (a load and then eight steps), so strings shorter than 9 bytes
// arriving back to back are limited by that unit. req_stall rises only
// while the job queue is full. While rsp_stall is high the result
// register holds its beat; the unit finishes the next string and waits,
// and the parser keeps taking bytes until the queue fills. Reset is
// synchronous and leaves the parser expecting a new string with an
// empty queue and no result pending.
module xsd_duration_to_ticks_parser_core #(
   parameter int unsigned FIFO_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  xsdd_pkg::req_type req_data,
   output logic              req_stall,
   output logic              rsp_valid,
   output xsdd_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);

   logic              push, pop, full, empty;
   xsdd_pkg::job_type push_data, pop_data;

   assign req_stall = full;

   xsdd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .push      (push),
      .job       (push_data)
   );

   xsdd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   xsdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (!empty),
      .job_data  (pop_data),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from an empty queue");

   a_ticks_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != xsdd_pkg::ST_OK |-> rsp_data.ticks == 64'sd0)
      else $error("non-zero ticks with an error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == xsdd_pkg::ST_OK ||
                     rsp_data.status == xsdd_pkg::ST_FMT ||
                     rsp_data.status == xsdd_pkg::ST_OVF))
      else $error("undefined status code");
`endif

endmodule

[tb/tb_xsd_duration_to_ticks_parser_core.sv]
`timescale 1ns / 1ps

module tb_xsd_duration_to_ticks_parser_core;

   logic              clock;
   logic              reset;
   logic              req_valid;
   xsdd_pkg::req_type req_data;
   logic              req_stall;
   logic              rsp_valid;
   xsdd_pkg::rsp_type rsp_data;
   logic              rsp_stall;

   xsd_duration_to_ticks_parser_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // parser state mirror
   xsdd_pkg::phase_type dur_phase;
   logic                dur_neg;
   logic [30:0]         dur_acc;
   logic [3:0]          dur_ndig;
   logic [30:0]         dur_comp [6];
   logic [29:0]         dur_frac;
   logic                dur_any;
   logic [1:0]          dur_err;

   xsdd_pkg::rsp_type expected_durations[$];
   int      fail_count;
   int      strings_sent;
   int      bytes_sent;
   int      status_seen[3];
   bit      idle_on;

   function automatic void clear_parse();
      dur_phase = xsdd_pkg::PH_START;
      dur_neg   = 1'b0;
      dur_acc   = '0;
      dur_ndig  = '0;
      for (int i = 0; i < 6; i++) dur_comp[i] = '0;
      dur_frac  = '0;
      dur_any   = 1'b0;
      dur_err   = xsdd_pkg::ST_OK;
   endfunction

   function automatic void flag_error(logic [1:0] code);
      if (dur_err == xsdd_pkg::ST_OK) dur_err = code;
   endfunction

   function automatic void store_comp(logic [2:0] idx, xsdd_pkg::phase_type nxt);
      if (dur_ndig == 0) begin
         flag_error(xsdd_pkg::ST_FMT);
         return;
      end
      dur_comp[idx] = dur_acc;
      dur_any  = 1'b1;
      dur_acc  = '0;
      dur_ndig = '0;
      dur_phase = nxt;
   endfunction

   function automatic void parse_byte(logic [7:0] c);
      logic [31:0]         d;
      xsdd_pkg::phase_type ph;
      logic [29:0]         f;
      int                  n;
      ph = dur_phase;
      if (c >= xsdd_pkg::CH_ZERO && c <= xsdd_pkg::CH_NINE) begin
         d = 32'(c - xsdd_pkg::CH_ZERO);
         if (ph == xsdd_pkg::PH_FRAC) begin
            if (dur_ndig < 9) begin
               dur_frac = 30'(dur_frac * 10 + d);
               dur_ndig++;
            end
         end else if (ph >= xsdd_pkg::PH_P0 && ph <= xsdd_pkg::PH_T2) begin
            if (32'(dur_acc) > (32'(xsdd_pkg::COMP_MAX) - d) / 10) begin
               flag_error(xsdd_pkg::ST_OVF);
               return;
            end
            dur_acc = 31'(dur_acc * 10 + d);
            if (dur_ndig < 15) dur_ndig++;
         end else begin
            flag_error(xsdd_pkg::ST_FMT);
         end
         return;
      end
      if (ph == xsdd_pkg::PH_START && c == xsdd_pkg::CH_MINUS) begin
         dur_neg = 1'b1;
         dur_phase = xsdd_pkg::PH_SIGNED;
      end else if ((ph == xsdd_pkg::PH_START || ph == xsdd_pkg::PH_SIGNED)
                   && c == xsdd_pkg::CH_P) begin
         dur_phase = xsdd_pkg::PH_P0;
      end else if (c == xsdd_pkg::CH_Y && ph == xsdd_pkg::PH_P0) begin
         store_comp(xsdd_pkg::CI_YEAR, xsdd_pkg::PH_P1);
      end else if (c == xsdd_pkg::CH_M && (ph == xsdd_pkg::PH_P0 ||
                                           ph == xsdd_pkg::PH_P1)) begin
         store_comp(xsdd_pkg::CI_MONTH, xsdd_pkg::PH_P2);
      end else if (c == xsdd_pkg::CH_D && ph >= xsdd_pkg::PH_P0
                   && ph <= xsdd_pkg::PH_P2) begin
         store_comp(xsdd_pkg::CI_DAY, xsdd_pkg::PH_P3);
      end else if (c == xsdd_pkg::CH_T && ph >= xsdd_pkg::PH_P0
                   && ph <= xsdd_pkg::PH_P3) begin
         if (dur_ndig != 0) flag_error(xsdd_pkg::ST_FMT);
         else dur_phase = xsdd_pkg::PH_T0;
      end else if (c == xsdd_pkg::CH_H && ph == xsdd_pkg::PH_T0) begin
         store_comp(xsdd_pkg::CI_HOUR, xsdd_pkg::PH_T1);
      end else if (c == xsdd_pkg::CH_M && (ph == xsdd_pkg::PH_T0 ||
                                           ph == xsdd_pkg::PH_T1)) begin
         store_comp(xsdd_pkg::CI_MIN, xsdd_pkg::PH_T2);
      end else if (c == xsdd_pkg::CH_DOT && ph >= xsdd_pkg::PH_T0
                   && ph <= xsdd_pkg::PH_T2) begin
         dur_comp[xsdd_pkg::CI_SEC] = dur_acc;
         dur_any  = 1'b1;
         dur_acc  = '0;
         dur_ndig = '0;
         dur_frac = '0;
         dur_phase = xsdd_pkg::PH_FRAC;
      end else if (c == xsdd_pkg::CH_S && ph >= xsdd_pkg::PH_T0
                   && ph <= xsdd_pkg::PH_T2) begin
         store_comp(xsdd_pkg::CI_SEC, xsdd_pkg::PH_DONE);
      end else if (c == xsdd_pkg::CH_S && ph == xsdd_pkg::PH_FRAC) begin
         f = dur_frac;
         for (n = int'(dur_ndig); n < 9; n++) f = 30'(f * 10);
         dur_frac = f;
         dur_ndig = '0;
         dur_phase = xsdd_pkg::PH_DONE;
      end else begin
         flag_error(xsdd_pkg::ST_FMT);
      end
   endfunction

   function automatic xsdd_pkg::rsp_type finish_duration();
      xsdd_pkg::rsp_type r;
      logic [63:0]       t;
      logic              ends_ok;
      r.status = xsdd_pkg::ST_OK;
      r.ticks  = '0;
      ends_ok = (dur_phase inside {xsdd_pkg::PH_P1, xsdd_pkg::PH_P2, xsdd_pkg::PH_P3,
                                   xsdd_pkg::PH_T1, xsdd_pkg::PH_T2, xsdd_pkg::PH_DONE})
                && dur_ndig == 0 && dur_any;
      if (dur_err != xsdd_pkg::ST_OK) r.status = dur_err;
      else if (!ends_ok) r.status = xsdd_pkg::ST_FMT;
      else begin
         t = (64'(dur_comp[xsdd_pkg::CI_YEAR]) + 64'(dur_comp[xsdd_pkg::CI_MONTH]) / 12)
             * 365;
         t += (64'(dur_comp[xsdd_pkg::CI_MONTH]) % 12) * 30;
         t += 64'(dur_comp[xsdd_pkg::CI_DAY]);
         t = t * 24 + 64'(dur_comp[xsdd_pkg::CI_HOUR]);
         t = t * 60 + 64'(dur_comp[xsdd_pkg::CI_MIN]);
         t = t * 60 + 64'(dur_comp[xsdd_pkg::CI_SEC]);
         if (t > xsdd_pkg::SEC_MAX) r.status = xsdd_pkg::ST_OVF;
         else begin
            t = t * 64'(xsdd_pkg::TICKS_PER_SEC) + 64'(dur_frac) / 100;
            if (dur_neg) begin
               if (t > xsdd_pkg::NEG_MAX) r.status = xsdd_pkg::ST_OVF;
               else r.ticks = -t;
            end else begin
               if (t > xsdd_pkg::POS_MAX) r.status = xsdd_pkg::ST_OVF;
               else r.ticks = t;
            end
         end
      end
      clear_parse();
      return r;
   endfunction

   task automatic send_byte(logic [7:0] c, logic last);
      while (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, last_char: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (dur_err == xsdd_pkg::ST_OK) parse_byte(c);
      bytes_sent++;
      if (last) begin
         expected_durations.push_back(finish_duration());
         strings_sent++;
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_durations.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= idle_on && ($urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      xsdd_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_durations.size() == 0) begin
            $display("%0t: unexpected result status=%0d ticks=%0d", $time,
                     rsp_data.status, rsp_data.ticks);
            fail_count++;
         end else begin
            exp_r = expected_durations.pop_front();
            status_seen[exp_r.status]++;
            if (rsp_data.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_r.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.ticks !== exp_r.ticks) begin
               $display("%0t: ticks expected %0d actual %0d", $time,
                        exp_r.ticks, rsp_data.ticks);
               fail_count++;
            end
         end
      end
   end

   function automatic string rand_num(int maxlen);
      string s;
      int    n;
      s = "";
      n = $urandom_range(maxlen, 1);
      for (int i = 0; i < n; i++) s = {s, string'(8'h30 + 8'($urandom_range(9)))};
      return s;
   endfunction

   function automatic string rand_duration();
      string s;
      logic  any_t;
      s = ($urandom_range(1)) ? "-P" : "P";
      if ($urandom_range(2) == 0) s = {s, rand_num(4), "Y"};
      if ($urandom_range(2) == 0) s = {s, rand_num(4), "M"};
      if ($urandom_range(2) == 0) s = {s, rand_num(5), "D"};
      any_t = $urandom_range(3) != 0;
      if (any_t) begin
         s = {s, "T"};
         if ($urandom_range(1)) s = {s, rand_num(3), "H"};
         if ($urandom_range(1)) s = {s, rand_num(3), "M"};
         case ($urandom_range(3))
            0: s = {s, rand_num(4), "S"};
            1: s = {s, rand_num(4), ".", rand_num(12), "S"};
            2: s = {s, ".", rand_num(3), "S"};
            default: ;
         endcase
      end
      // occasional huge component
      if ($urandom_range(15) == 0) s = {s, "T", rand_num(11), "H"};
      return s;
   endfunction

   task automatic test_directed();
      send_text("P1Y2M3DT4H5M6.7S");
      send_text("-P1D");
      send_text("PT.5S");
      send_text("PT1.S");
      send_text("PT1.1234567891234S");
      send_text("P2147483647D");
      send_text("P2147483648D");
      send_text("P2147483647YT1S");
      send_text("-P0D");
      send_text("P1D2Y");
      send_text("P5H");
      send_text("PY");
      send_text("PT");
      send_text("P");
      send_text("P1");
      send_text("PT1.5");
      send_text("PT1S1");
      send_text("P1DT1MX");
      send_text("PT2147483647H2147483647M2147483647S");
      send_text("P13M");
      send_text("-P29227YT1S");
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      drain_results();
   endtask

   task automatic test_random_durations(int upto);
      string s;
      int    k;
      while (bytes_sent < upto) begin
         s = rand_duration();
         if ($urandom_range(9) == 0) begin
            k = $urandom_range(s.len() - 1);
            s[k] = 8'($urandom_range(255));
         end
         if ($urandom_range(9) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
         send_text(s);
      end
   endtask

   task automatic test_random_bytes();
      for (int i = 0; i < 60; i++)
         send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      send_byte(8'($urandom_range(255)), 1'b1);
   endtask

   initial begin
      fail_count = 0;
      strings_sent = 0;
      bytes_sent = 0;
      status_seen = '{0, 0, 0};
      idle_on = 1'b1;
      clear_parse();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_durations(450);
      idle_on = 1'b0;
      test_random_bytes();
      repeat (20) send_text(rand_duration());
      idle_on = 1'b1;
      test_random_durations(850);
      drain_results();
      repeat (30) @(posedge clock);
      $display("Sent %0d strings in %0d bytes; status ok/format/overflow: %0d/%0d/%0d",
               strings_sent, bytes_sent, status_seen[0], status_seen[1], status_seen[2]);
      if (fail_count == 0 && expected_durations.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
